>>> design/psm_pkg.sv
package psm_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int LIGHT_W     = 16;
  localparam int OUT_W       = 48;
  localparam int NORM_FRAC   = 14;
  localparam int CFG_IDX_W   = 3;

  localparam int E_W      = COORD_WIDTH + 1;
  localparam int PR_W     = 2 * E_W;
  localparam int CR_W     = PR_W + 1;
  localparam int POS_W    = $clog2(CR_W);
  localparam int U_W      = 30;
  localparam int SH_W     = CR_W + U_W;
  localparam int SQ_W     = 2 * U_W;
  localparam int SUM_W    = SQ_W + 2;
  localparam int R_W      = SUM_W / 2;
  localparam int SQRT_STG = R_W;
  localparam int Q_W      = NORM_FRAC + 1;
  localparam int DIV_STG  = Q_W;
  localparam int NUM_W    = U_W + NORM_FRAC + 2;
  localparam int DEN_W    = R_W + 1;
  localparam int N_W      = NORM_FRAC + 2;
  localparam int T_W      = N_W + COORD_WIDTH + 2;
  localparam int D_W      = T_W - 7;
  localparam int ENT_W    = LIGHT_W + D_W + 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIGHT_X = 3'd0,
    REG_LIGHT_Y = 3'd1,
    REG_LIGHT_Z = 3'd2,
    REG_LIGHT_W = 3'd3
  } psm_reg_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] p0_x;
    logic signed [COORD_WIDTH-1:0] p0_y;
    logic signed [COORD_WIDTH-1:0] p0_z;
    logic signed [COORD_WIDTH-1:0] p1_x;
    logic signed [COORD_WIDTH-1:0] p1_y;
    logic signed [COORD_WIDTH-1:0] p1_z;
    logic signed [COORD_WIDTH-1:0] p2_x;
    logic signed [COORD_WIDTH-1:0] p2_y;
    logic signed [COORD_WIDTH-1:0] p2_z;
  } psm_req_t;

  typedef struct packed {
    logic [1:0]              column;
    logic signed [OUT_W-1:0] row0;
    logic signed [OUT_W-1:0] row1;
    logic signed [OUT_W-1:0] row2;
    logic signed [OUT_W-1:0] row3;
    logic                    last;
  } psm_result_t;

  typedef struct packed {
    logic [2:0][U_W-1:0]                 u;
    logic [2:0]                          neg;
    logic                                zero;
    logic [2:0][COORD_WIDTH-1:0]         p2;
  } psm_side_t;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ENT_W-1:0] v);
    logic signed [63:0] w;
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    w  = 64'(v);
    hi = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (w > hi) w = hi;
    if (w < lo) w = lo;
    return w[OUT_W-1:0];
  endfunction

endpackage

>>> design/psm_sqrt.sv
module psm_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [psm_pkg::SUM_W-1:0]   in_sum,
  input  psm_pkg::psm_side_t          in_side,
  output logic                        out_valid,
  output logic [psm_pkg::R_W-1:0]     out_root,
  output psm_pkg::psm_side_t          out_side
);
  import psm_pkg::*;

  logic [SUM_W-1:0] x   [SQRT_STG+1];
  logic [SUM_W-1:0] res [SQRT_STG+1];
  logic             vld [SQRT_STG+1];
  psm_side_t        sd  [SQRT_STG+1];

  assign x[0]   = in_sum;
  assign res[0] = '0;
  assign vld[0] = in_valid;
  assign sd[0]  = in_side;

  for (genvar j = 0; j < SQRT_STG; j++) begin : g_stage
    localparam logic [SUM_W-1:0] BITV = SUM_W'(1) << (2 * (SQRT_STG - 1 - j));
    logic [SUM_W-1:0] trial;
    logic [SUM_W-1:0] x_next;
    logic [SUM_W-1:0] res_next;
    always_comb begin
      trial = res[j] + BITV;
      if (x[j] >= trial) begin
        x_next   = x[j] - trial;
        res_next = (res[j] >> 1) + BITV;
      end else begin
        x_next   = x[j];
        res_next = res[j] >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) vld[j+1] <= 1'b0;
      else     vld[j+1] <= vld[j];
      x[j+1]   <= x_next;
      res[j+1] <= res_next;
      sd[j+1]  <= sd[j];
    end
  end

  assign out_valid = vld[SQRT_STG];
  assign out_root  = res[SQRT_STG][R_W-1:0];
  assign out_side  = sd[SQRT_STG];

endmodule

>>> design/psm_div.sv
module psm_div (
  input  logic                              clk,
  input  logic [psm_pkg::NUM_W-1:0]         num,
  input  logic [psm_pkg::DEN_W-1:0]         den,
  input  logic                              neg,
  output logic signed [psm_pkg::N_W-1:0]    quot
);
  import psm_pkg::*;

  logic [NUM_W-1:0] rem [DIV_STG+1];
  logic [DEN_W-1:0] dd  [DIV_STG+1];
  logic [Q_W-1:0]   qq  [DIV_STG+1];
  logic             ng  [DIV_STG+1];

  assign rem[0] = num;
  assign dd[0]  = den;
  assign qq[0]  = '0;
  assign ng[0]  = neg;

  for (genvar i = 0; i < DIV_STG; i++) begin : g_stage
    localparam int B = Q_W - 1 - i;
    logic [NUM_W:0] sh;
    logic [NUM_W:0] rx;
    always_comb begin
      sh = (NUM_W+1)'(dd[i]) << B;
      rx = {1'b0, rem[i]};
    end
    always_ff @(posedge clk) begin
      dd[i+1] <= dd[i];
      ng[i+1] <= ng[i];
      if (rx >= sh) begin
        rem[i+1] <= NUM_W'(rx - sh);
        qq[i+1]  <= qq[i] | (Q_W'(1) << B);
      end else begin
        rem[i+1] <= rem[i];
        qq[i+1]  <= qq[i];
      end
    end
  end

  assign quot = ng[DIV_STG] ? -N_W'(qq[DIV_STG]) : N_W'(qq[DIV_STG]);

endmodule

>>> design/planar_shadow_matrix_top.sv
// Planar shadow matrix generator.
// Request: start with the three plane points on req; taken when busy is low.
// busy stays high after each request while the cool counter runs down to zero;
// a new request may enter while earlier ones are still in flight; the spacing is
// set by the single result channel, which carries the four columns of a request.
// Results: strobe marks each column for one cycle, columns 0..3 back to back,
// last set on column 3. There is no result backpressure; the receiver takes
// every strobed column.
// Pipeline: edge, cross and normalize stages, the pipelined square root (31
// stages), the per-lane normal dividers (15 stages), then plane and dot stages.
// Light position: cfg_valid/cfg_index/cfg_data, always ready; write only
// while no request is in flight. Unknown indexes are dropped.
// Reset (rst, synchronous): pipeline emptied, busy low, light = (0, 0, 256, 0).
module planar_shadow_matrix_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  psm_pkg::psm_req_t                   req,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [psm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [psm_pkg::LIGHT_W-1:0]         cfg_data,
  output logic                                strobe,
  output psm_pkg::psm_result_t                result
);
  import psm_pkg::*;

  logic signed [LIGHT_W-1:0] light [4];
  logic [1:0] cool;
  logic acc;

  assign acc       = start && !busy;
  assign busy      = (cool != 2'd0);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      light[0] <= '0;
      light[1] <= '0;
      light[2] <= LIGHT_W'(256);
      light[3] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LIGHT_X: light[0] <= cfg_data;
        REG_LIGHT_Y: light[1] <= cfg_data;
        REG_LIGHT_Z: light[2] <= cfg_data;
        REG_LIGHT_W: light[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst)          cool <= 2'd0;
    else if (acc)     cool <= 2'd3;
    else if (busy)    cool <= cool - 2'd1;
  end

  // edges
  logic v1;
  logic signed [E_W-1:0] e1 [3];
  logic signed [E_W-1:0] e2 [3];
  logic [2:0][COORD_WIDTH-1:0] p2_1, p2_2, p2_3, p2_4, p2_5, p2_6;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= acc;
    e1[0] <= E_W'(req.p0_x) - E_W'(req.p1_x);
    e1[1] <= E_W'(req.p0_y) - E_W'(req.p1_y);
    e1[2] <= E_W'(req.p0_z) - E_W'(req.p1_z);
    e2[0] <= E_W'(req.p1_x) - E_W'(req.p2_x);
    e2[1] <= E_W'(req.p1_y) - E_W'(req.p2_y);
    e2[2] <= E_W'(req.p1_z) - E_W'(req.p2_z);
    p2_1  <= {req.p2_z, req.p2_y, req.p2_x};
  end

  // cross products
  logic v2;
  logic signed [PR_W-1:0] pr [6];
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    pr[0] <= e1[1] * e2[2];
    pr[1] <= e1[2] * e2[1];
    pr[2] <= e1[2] * e2[0];
    pr[3] <= e1[0] * e2[2];
    pr[4] <= e1[0] * e2[1];
    pr[5] <= e1[1] * e2[0];
    p2_2  <= p2_1;
  end

  logic v3;
  logic [CR_W-1:0] mag3 [3];
  logic [2:0] neg3;
  for (genvar k = 0; k < 3; k++) begin : g_cross
    logic signed [CR_W-1:0] cr;
    assign cr = CR_W'(pr[2*k]) - CR_W'(pr[2*k+1]);
    always_ff @(posedge clk) begin
      mag3[k] <= cr[CR_W-1] ? CR_W'(-cr) : CR_W'(cr);
      neg3[k] <= cr[CR_W-1];
    end
  end
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
    p2_3 <= p2_2;
  end

  // largest magnitude and its leading one
  logic v4, zero4;
  logic [CR_W-1:0] mag4 [3];
  logic [2:0] neg4;
  logic [POS_W-1:0] pos4;
  logic [CR_W-1:0] mx;
  logic [POS_W-1:0] pos_c;
  always_comb begin
    mx = mag3[0];
    if (mag3[1] > mx) mx = mag3[1];
    if (mag3[2] > mx) mx = mag3[2];
    pos_c = '0;
    for (int i = 0; i < CR_W; i++) begin
      if (mx[i]) pos_c = POS_W'(i);
    end
  end
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else     v4 <= v3;
    mag4  <= mag3;
    neg4  <= neg3;
    pos4  <= pos_c;
    zero4 <= (mx == '0);
    p2_4  <= p2_3;
  end

  // normalize so the largest magnitude lies in [2^29, 2^30)
  logic v5, zero5;
  logic [2:0] neg5;
  logic [U_W-1:0] u5 [3];
  for (genvar k = 0; k < 3; k++) begin : g_norm
    logic [SH_W-1:0] w;
    always_comb begin
      if (32'(pos4) >= U_W - 1) w = SH_W'(mag4[k]) >> (32'(pos4) - (U_W - 1));
      else                      w = SH_W'(mag4[k]) << ((U_W - 1) - 32'(pos4));
    end
    always_ff @(posedge clk) u5[k] <= w[U_W-1:0];
  end
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else     v5 <= v4;
    neg5  <= neg4;
    zero5 <= zero4;
    p2_5  <= p2_4;
  end

  // squares, one lane per component
  logic v6, zero6;
  logic [2:0] neg6;
  logic [U_W-1:0] u6 [3];
  logic [SQ_W-1:0] sq6 [3];
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else     v6 <= v5;
    for (int k = 0; k < 3; k++) begin
      sq6[k] <= u5[k] * u5[k];
    end
    u6    <= u5;
    neg6  <= neg5;
    zero6 <= zero5;
    p2_6  <= p2_5;
  end

  logic [SUM_W-1:0] ssum;
  psm_side_t side6, side_s;
  logic vs;
  logic [R_W-1:0] root;
  assign ssum = SUM_W'(sq6[0]) + SUM_W'(sq6[1]) + SUM_W'(sq6[2]);
  always_comb begin
    side6.u    = {u6[2], u6[1], u6[0]};
    side6.neg  = neg6;
    side6.zero = zero6;
    side6.p2   = p2_6;
  end

  psm_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v6),
    .in_sum    (ssum),
    .in_side   (side6),
    .out_valid (vs),
    .out_root  (root),
    .out_side  (side_s)
  );

  logic signed [N_W-1:0] q [3];
  for (genvar k = 0; k < 3; k++) begin : g_div
    logic [NUM_W-1:0] num;
    assign num = (NUM_W'(side_s.u[k]) << (NORM_FRAC + 1)) + NUM_W'(root);
    psm_div u_div (
      .clk  (clk),
      .num  (num),
      .den  ({root, 1'b0}),
      .neg  (side_s.neg[k]),
      .quot (q[k])
    );
  end

  logic                        dv [DIV_STG];
  logic                        dz [DIV_STG];
  logic [2:0][COORD_WIDTH-1:0] dp [DIV_STG];
  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else     dv[0] <= vs;
    dz[0] <= side_s.zero;
    dp[0] <= side_s.p2;
    for (int i = 1; i < DIV_STG; i++) begin
      if (rst) dv[i] <= 1'b0;
      else     dv[i] <= dv[i-1];
      dz[i] <= dz[i-1];
      dp[i] <= dp[i-1];
    end
  end

  // plane offset
  logic vt1, vt2, vt3;
  logic signed [N_W-1:0] n1 [3];
  logic signed [N_W-1:0] n2 [3];
  logic signed [N_W-1:0] n3 [3];
  logic signed [T_W-1:0] tp [3];
  logic signed [T_W-1:0] t2;
  logic signed [D_W-1:0] d3;
  logic [T_W-1:0] tm;
  logic [T_W-1:0] rd;
  always_comb begin
    tm = t2[T_W-1] ? T_W'(-t2) : T_W'(t2);
    rd = (tm + T_W'(128)) >> 8;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      vt1 <= 1'b0;
      vt2 <= 1'b0;
      vt3 <= 1'b0;
    end else begin
      vt1 <= dv[DIV_STG-1];
      vt2 <= vt1;
      vt3 <= vt2;
    end
    for (int k = 0; k < 3; k++) begin
      n1[k] <= dz[DIV_STG-1] ? N_W'(0) : q[k];
      tp[k] <= T_W'(dz[DIV_STG-1] ? N_W'(0) : q[k])
             * T_W'($signed(dp[DIV_STG-1][k]));
    end
    t2 <= tp[0] + tp[1] + tp[2];
    n2 <= n1;
    d3 <= t2[T_W-1] ? D_W'(rd) : -D_W'(rd);
    n3 <= n2;
  end

  // plane dot light
  logic vp1;
  logic signed [D_W-1:0] pl1 [4];
  logic signed [ENT_W-1:0] dpr [4];
  always_ff @(posedge clk) begin
    if (rst) vp1 <= 1'b0;
    else     vp1 <= vt3;
    for (int k = 0; k < 3; k++) begin
      pl1[k] <= D_W'(n3[k]);
      dpr[k] <= ENT_W'(D_W'(n3[k])) * ENT_W'(light[k]);
    end
    pl1[3] <= d3;
    dpr[3] <= ENT_W'(d3) * ENT_W'(light[3]);
  end

  // column emitter
  logic signed [D_W-1:0]   hpl [4];
  logic signed [ENT_W-1:0] hdot;
  logic [1:0] col;
  logic act;
  always_ff @(posedge clk) begin
    if (rst) begin
      act <= 1'b0;
      col <= 2'd0;
    end else if (vp1) begin
      act <= 1'b1;
      col <= 2'd0;
    end else if (act) begin
      col <= col + 2'd1;
      if (col == 2'd3) act <= 1'b0;
    end
    if (vp1) begin
      hpl  <= pl1;
      hdot <= dpr[0] + dpr[1] + dpr[2] + dpr[3];
    end
  end

  logic signed [OUT_W-1:0] ent [4];
  for (genvar r = 0; r < 4; r++) begin : g_ent
    logic signed [ENT_W-1:0] prod;
    logic signed [ENT_W-1:0] e;
    always_comb begin
      prod = ENT_W'(light[col]) * ENT_W'(hpl[r]);
      e    = ((col == 2'(r)) ? hdot : ENT_W'(0)) - prod;
      ent[r] = sat_out(e);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) strobe <= 1'b0;
    else     strobe <= act;
    result.column <= col;
    result.row0   <= ent[0];
    result.row1   <= ent[1];
    result.row2   <= ent[2];
    result.row3   <= ent[3];
    result.last   <= (col == 2'd3);
  end

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    acc |=> busy && cool == 2'd3)
    else $error("busy not raised after request");
  a_columns_run: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |=> strobe && result.column == $past(result.column) + 2'd1)
    else $error("column sequence broken");
  a_last_col: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (result.last == (result.column == 2'd3)))
    else $error("last flag out of place");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    vp1 |-> !act || col == 2'd3)
    else $error("new matrix before previous columns sent");

endmodule
